// File: rtl/qpn_pkg.sv
// Shared constants and types for the quaternion product normalizer.
package qpn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int NORM_TOP  = 29;
  localparam int CW   = 34;               // width of one Hamilton product sum
  localparam int AW   = CW - 1;           // magnitude of a product sum
  localparam int SHW  = 6;                // top-bit index of an AW-bit word
  localparam int NAW  = NORM_TOP + 1;     // normalized magnitude width
  localparam int SW   = 2 * NAW + 2;      // sum of four squares
  localparam int RTW  = SW / 2;           // integer square root width
  localparam int RMW  = RTW + 4;          // square root remainder width
  localparam int MW   = RTW + 1;          // rounded magnitude width
  localparam int QW   = FRAC_BITS + 1;    // quotient width
  localparam int NW   = NAW + QW;         // dividend width
  localparam int DRW  = MW + 1;           // divider remainder width
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam logic [15:0] OUT_MAX = 16'd32767;
  localparam int RMAX = (FRAC_BITS > 14) ? 32767 : (2 ** FRAC_BITS);

  typedef logic [NAW-1:0] norm_t;

  typedef struct packed {
    norm_t [3:0]   a;
    logic  [3:0]   neg;
    logic          zero;
    logic [SW-1:0] s;
  } qpn_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qpn_q_stat_t;

endpackage

// File: rtl/qpn_in_if.sv
// Input channel: two quaternions per beat.
interface qpn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  logic signed [15:0] p_w;
  logic signed [15:0] p_x;
  logic signed [15:0] p_y;
  logic signed [15:0] p_z;
  modport source (output valid, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, output ready);
endinterface

// File: rtl/qpn_out_if.sv
// Result channel: one normalized quaternion per beat.
interface qpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_w;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [15:0] r_z;
  logic               zero_magnitude;
  modport source (output valid, r_w, r_x, r_y, r_z, zero_magnitude, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, zero_magnitude, output ready);
endinterface

// File: rtl/qpn_front.sv
// Front pipeline: Hamilton product, magnitudes, normalizing shift, sum of squares.
module qpn_front (
  input  logic                 clk,
  input  logic                 rst_n,
  qpn_in_if.sink               in_ch,
  input  qpn_pkg::qpn_q_stat_t stat,
  output logic                 push,
  output qpn_pkg::qpn_item_t   wr_item
);
  import qpn_pkg::*;

  logic fen;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [15:0] qv [0:3];
  logic signed [15:0] pv [0:3];
  logic signed [31:0] pr_r [0:3][0:3];

  logic signed [CW-1:0] c [0:3];
  logic [AW-1:0]  a2_r [0:3];
  logic [3:0]     neg2_r, neg3_r, neg4_r, neg5_r;
  logic [AW-1:0]  a3_r [0:3];
  logic [SHW-1:0] tb_nxt, tb3_r;
  logic [AW-1:0]  orv;
  logic           zero3_r, zero4_r, zero5_r;
  norm_t          n4_r [0:3];
  norm_t          n5_r [0:3];
  logic [2*NAW-1:0] sq5_r [0:3];
  qpn_item_t      item6_r;

  assign fen = !v6_r || !stat.full;
  assign in_ch.ready = fen;
  assign push = v6_r && !stat.full;
  assign wr_item = item6_r;

  assign qv[0] = in_ch.q_w;
  assign qv[1] = in_ch.q_x;
  assign qv[2] = in_ch.q_y;
  assign qv[3] = in_ch.q_z;
  assign pv[0] = in_ch.p_w;
  assign pv[1] = in_ch.p_x;
  assign pv[2] = in_ch.p_y;
  assign pv[3] = in_ch.p_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (fen) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // sixteen partial products
  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_r[i][j] <= 32'(qv[i] * pv[j]);
        end
      end
    end
  end

  assign c[0] = CW'(pr_r[0][0]) - CW'(pr_r[1][1]) - CW'(pr_r[2][2]) - CW'(pr_r[3][3]);
  assign c[1] = CW'(pr_r[0][1]) + CW'(pr_r[1][0]) + CW'(pr_r[2][3]) - CW'(pr_r[3][2]);
  assign c[2] = CW'(pr_r[0][2]) - CW'(pr_r[1][3]) + CW'(pr_r[2][0]) + CW'(pr_r[3][1]);
  assign c[3] = CW'(pr_r[0][3]) + CW'(pr_r[1][2]) - CW'(pr_r[2][1]) + CW'(pr_r[3][0]);

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 4; i++) begin
        neg2_r[i] <= c[i][CW-1];
        a2_r[i]   <= c[i][CW-1] ? AW'(-c[i]) : AW'(c[i]);
      end
    end
  end

  // the top bit of the largest magnitude is the top bit of their OR
  assign orv = a2_r[0] | a2_r[1] | a2_r[2] | a2_r[3];

  always_comb begin
    tb_nxt = '0;
    for (int k = 0; k < AW; k++) begin
      if (orv[k]) tb_nxt = SHW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      a3_r    <= a2_r;
      neg3_r  <= neg2_r;
      tb3_r   <= tb_nxt;
      zero3_r <= (orv == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 4; i++) begin
        if (tb3_r > SHW'(NORM_TOP)) begin
          n4_r[i] <= NAW'(a3_r[i] >> (tb3_r - SHW'(NORM_TOP)));
        end else begin
          n4_r[i] <= NAW'(a3_r[i] << (SHW'(NORM_TOP) - tb3_r));
        end
      end
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 4; i++) begin
        sq5_r[i] <= n4_r[i] * n4_r[i];
      end
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
    end
  end

  // hold the magnitudes one more stage so they line up with the sum
  always_ff @(posedge clk) begin
    if (fen) n5_r <= n4_r;
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      item6_r.s <= SW'(sq5_r[0]) + SW'(sq5_r[1]) + SW'(sq5_r[2]) + SW'(sq5_r[3]);
      for (int i = 0; i < 4; i++) begin
        item6_r.a[i] <= n5_r[i];
      end
      item6_r.neg  <= neg5_r;
      item6_r.zero <= zero5_r;
    end
  end

endmodule

// File: rtl/qpn_fifo.sv
// Short queue between the front and back pipelines.
module qpn_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  qpn_pkg::qpn_item_t   wr_item,
  input  logic                 pop,
  output qpn_pkg::qpn_item_t   rd_item,
  output qpn_pkg::qpn_q_stat_t stat
);
  import qpn_pkg::*;

  qpn_item_t      mem_r [0:QDEPTH-1];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

// File: rtl/qpn_back.sv
// Back pipeline: square root, rounding, four-lane division and output register.
module qpn_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qpn_pkg::qpn_item_t   item,
  input  qpn_pkg::qpn_q_stat_t stat,
  output logic                 item_pop,
  qpn_out_if.source            out_ch
);
  import qpn_pkg::*;

  typedef struct packed {
    norm_t [3:0] a;
    logic  [3:0] neg;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } dside_t;

  logic ben;
  logic out_valid_r;
  logic [15:0] r_r [0:3];
  logic zero_r;

  assign ben = !out_valid_r || out_ch.ready;
  assign item_pop = ben && !stat.empty;

  // square root, two bits of the radicand a stage
  logic           sv_r   [0:RTW];
  side_t          sd_r   [0:RTW];
  logic [SW-1:0]  s_r    [0:RTW];
  logic [RTW-1:0] root_r [0:RTW];
  logic [RMW-1:0] rem_r  [0:RTW];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (ben) sv_r[0] <= item_pop;
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      sd_r[0].a    <= item.a;
      sd_r[0].neg  <= item.neg;
      sd_r[0].zero <= item.zero;
      s_r[0]       <= item.s;
      root_r[0]    <= '0;
      rem_r[0]     <= '0;
    end
  end

  genvar j;
  for (j = 0; j < RTW; j++) begin : g_sqrt
    logic [RMW-1:0] remsh, trial;
    logic           ge;
    assign remsh = {rem_r[j][RMW-3:0], s_r[j][SW-1-2*j -: 2]};
    assign trial = RMW'({root_r[j], 2'b01});
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j+1] <= 1'b0;
      else if (ben) sv_r[j+1] <= sv_r[j];
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        sd_r[j+1]   <= sd_r[j];
        s_r[j+1]    <= s_r[j];
        root_r[j+1] <= {root_r[j][RTW-2:0], ge};
        rem_r[j+1]  <= ge ? remsh - trial : remsh;
      end
    end
  end

  // round the root to nearest
  logic          mv_r;
  side_t         md_r;
  logic [MW-1:0] mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (ben) mv_r <= sv_r[RTW];
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      md_r  <= sd_r[RTW];
      mag_r <= (rem_r[RTW] > RMW'(root_r[RTW])) ? MW'(root_r[RTW]) + MW'(1)
                                                : MW'(root_r[RTW]);
    end
  end

  // restoring division, one quotient bit a stage in each lane
  logic                      dv_r  [0:QW];
  dside_t                    dsd_r [0:QW];
  logic [MW-1:0]             den_r [0:QW];
  logic [3:0][DRW-1:0]       dr_r  [0:QW];
  logic [3:0][QW-1:0]        lq_r  [0:QW];
  logic [3:0][NW-1:0]        num;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num[l] = (NW'(md_r.a[l]) << FRAC_BITS) + NW'(mag_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (ben) dv_r[0] <= mv_r;
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      dsd_r[0].neg  <= md_r.neg;
      dsd_r[0].zero <= md_r.zero;
      den_r[0]      <= mag_r;
      for (int l = 0; l < 4; l++) begin
        dr_r[0][l] <= DRW'(num[l][NW-1:QW]);
        lq_r[0][l] <= num[l][QW-1:0];
      end
    end
  end

  genvar k;
  for (k = 0; k < QW; k++) begin : g_div
    logic [3:0][DRW-1:0] dr_nxt;
    logic [3:0][QW-1:0]  lq_nxt;

    always_comb begin
      logic [DRW-1:0] x;
      logic           ge;
      for (int l = 0; l < 4; l++) begin
        x  = {dr_r[k][l][DRW-2:0], lq_r[k][l][QW-1]};
        ge = (x >= DRW'(den_r[k]));
        dr_nxt[l] = ge ? x - DRW'(den_r[k]) : x;
        lq_nxt[l] = {lq_r[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (ben) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        dsd_r[k+1] <= dsd_r[k];
        den_r[k+1] <= den_r[k];
        dr_r[k+1]  <= dr_nxt;
        lq_r[k+1]  <= lq_nxt;
      end
    end
  end

  // clamp, apply sign, drop results of a zero product
  logic [15:0] r_nxt [0:3];

  always_comb begin
    logic [QW+15:0] qx;
    logic [15:0]    m16;
    for (int l = 0; l < 4; l++) begin
      qx  = {16'd0, lq_r[QW][l]};
      m16 = (qx > (QW+16)'(OUT_MAX)) ? OUT_MAX : qx[15:0];
      if (dsd_r[QW].zero) r_nxt[l] = '0;
      else if (dsd_r[QW].neg[l]) r_nxt[l] = 16'd0 - m16;
      else r_nxt[l] = m16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ben) out_valid_r <= dv_r[QW];
  end

  always_ff @(posedge clk) begin
    if (ben && dv_r[QW]) begin
      r_r    <= r_nxt;
      zero_r <= dsd_r[QW].zero;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.r_w            = r_r[0];
  assign out_ch.r_x            = r_r[1];
  assign out_ch.r_y            = r_r[2];
  assign out_ch.r_z            = r_r[3];
  assign out_ch.zero_magnitude = zero_r;

endmodule

// File: rtl/quaternion_product_normalize.sv
// Top level: normalized Hamilton product of two Q2.14 quaternions.
// Throughput: one item per cycle unless out_ch stalls; the sqrt and divider pipelines each take a bit a stage.
// A four-entry queue lets the front keep accepting while the result side stalls, until the queue fills.
// Reset: synchronous active-low rst_n clears all valid bits and queue pointers.
module quaternion_product_normalize (
  input logic       clk,
  input logic       rst_n,
  qpn_in_if.sink    in_ch,
  qpn_out_if.source out_ch
);
  import qpn_pkg::*;

  logic        push, pop;
  qpn_item_t   wr_item, rd_item;
  qpn_q_stat_t stat;

  qpn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .stat    (stat),
    .push    (push),
    .wr_item (wr_item)
  );

  qpn_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (stat)
  );

  qpn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (rd_item),
    .stat     (stat),
    .item_pop (pop),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue read while empty");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_magnitude |->
      out_ch.r_w == 16'sd0 && out_ch.r_x == 16'sd0 &&
      out_ch.r_y == 16'sd0 && out_ch.r_z == 16'sd0)
    else $error("zero product gave nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.zero_magnitude |->
      int'(out_ch.r_w) <= RMAX && int'(out_ch.r_w) >= -RMAX &&
      int'(out_ch.r_x) <= RMAX && int'(out_ch.r_x) >= -RMAX)
    else $error("normalized component out of unit range");
`endif

endmodule
